@@ rtl/u8enc_pkg.sv @@
`default_nettype none

package u8enc_pkg;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic advance;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last_byte;
    } dp_status_t;

    localparam logic [31:0] LEN_MASK_1 = 32'hFFFF_FF80;
    localparam logic [31:0] LEN_MASK_2 = 32'hFFFF_F800;
    localparam logic [31:0] LEN_MASK_3 = 32'hFFFF_0000;
    localparam logic [31:0] LEN_MASK_4 = 32'hFFE0_0000;
    localparam logic [31:0] LEN_MASK_5 = 32'hFC00_0000;

    localparam logic [7:0] PREFIX_2 = 8'hC0;
    localparam logic [7:0] PREFIX_3 = 8'hE0;
    localparam logic [7:0] PREFIX_4 = 8'hF0;
    localparam logic [7:0] PREFIX_5 = 8'hF8;
    localparam logic [7:0] PREFIX_6 = 8'hFC;

    localparam logic [5:0] CONT_MASK   = 6'h3F;
    localparam logic [1:0] CONT_PREFIX = 2'b10;

    localparam logic [3:0] BYTE_LIMIT_RESET = 4'd8;

endpackage

`default_nettype wire

@@ rtl/u8enc_ctrl.sv @@
`default_nettype none

module u8enc_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output u8enc_pkg::dp_cmd_t         cmd,
    input  wire u8enc_pkg::dp_status_t status
);

    u8enc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= u8enc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            u8enc_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = u8enc_pkg::ST_EMIT;
            end
            u8enc_pkg::ST_EMIT: begin
                if (m_tready && status.last_byte) state_next = u8enc_pkg::ST_IDLE;
            end
            default: state_next = u8enc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        case (state_reg)
            u8enc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            u8enc_pkg::ST_EMIT: begin
                m_tvalid    = 1'b1;
                cmd.advance = m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/u8enc_datapath.sv @@
`default_nettype none

module u8enc_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [31:0]        code_point,
    input  wire logic               cfg_we,
    input  wire logic [3:0]         cfg_data,
    input  wire u8enc_pkg::dp_cmd_t cmd,
    output u8enc_pkg::dp_status_t   status,
    output logic [7:0]              out_byte,
    output logic [2:0]              byte_index,
    output logic [2:0]              reported_count
);

    logic [3:0]  byte_limit_reg;
    logic [31:0] cp_reg;
    logic [2:0]  len_reg, report_reg, emit_reg, idx_reg;
    logic [2:0]  len_next, report_next, emit_next, idx_next;
    logic [2:0]  group;
    logic [5:0]  cont_bits;
    logic [7:0]  lead_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_limit_reg <= u8enc_pkg::BYTE_LIMIT_RESET;
        end else if (cfg_we) begin
            byte_limit_reg <= cfg_data;
        end
    end

    always_comb begin
        if ((code_point & u8enc_pkg::LEN_MASK_1) == 32'd0)      len_next = 3'd1;
        else if ((code_point & u8enc_pkg::LEN_MASK_2) == 32'd0) len_next = 3'd2;
        else if ((code_point & u8enc_pkg::LEN_MASK_3) == 32'd0) len_next = 3'd3;
        else if ((code_point & u8enc_pkg::LEN_MASK_4) == 32'd0) len_next = 3'd4;
        else if ((code_point & u8enc_pkg::LEN_MASK_5) == 32'd0) len_next = 3'd5;
        else                                                    len_next = 3'd6;

        if ({1'b0, len_next} < byte_limit_reg) report_next = len_next;
        else                                   report_next = byte_limit_reg[2:0];

        // a zero limit still sends the lead byte
        emit_next = (report_next == 3'd0) ? 3'd1 : report_next;
        idx_next  = cmd.load ? 3'd0 : idx_reg + 3'd1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cp_reg     <= code_point;
            len_reg    <= len_next;
            report_reg <= report_next;
            emit_reg   <= emit_next;
        end
        if (cmd.load || cmd.advance) begin
            idx_reg <= idx_next;
        end
    end

    // six-bit group that feeds the current continuation byte
    assign group = len_reg - 3'd1 - idx_reg;

    always_comb begin
        case (group)
            3'd0:    cont_bits = cp_reg[5:0];
            3'd1:    cont_bits = cp_reg[11:6];
            3'd2:    cont_bits = cp_reg[17:12];
            3'd3:    cont_bits = cp_reg[23:18];
            3'd4:    cont_bits = cp_reg[29:24];
            default: cont_bits = {4'd0, cp_reg[31:30]};
        endcase
        cont_bits = cont_bits & u8enc_pkg::CONT_MASK;

        case (len_reg)
            3'd1:    lead_byte = cp_reg[7:0];
            3'd2:    lead_byte = cp_reg[13:6]  | u8enc_pkg::PREFIX_2;
            3'd3:    lead_byte = cp_reg[19:12] | u8enc_pkg::PREFIX_3;
            3'd4:    lead_byte = cp_reg[25:18] | u8enc_pkg::PREFIX_4;
            3'd5:    lead_byte = cp_reg[31:24] | u8enc_pkg::PREFIX_5;
            default: lead_byte = {6'd0, cp_reg[31:30]} | u8enc_pkg::PREFIX_6;
        endcase
    end

    assign out_byte         = (idx_reg == 3'd0) ? lead_byte : {u8enc_pkg::CONT_PREFIX, cont_bits};
    assign byte_index       = idx_reg;
    assign reported_count   = report_reg;
    assign status.last_byte = (idx_reg == emit_reg - 3'd1);

endmodule

`default_nettype wire

@@ rtl/utf8_sequence_encoder_core.sv @@
`default_nettype none

// channel  | dir | handshake              | payload
// s_       | in  | s_tvalid / s_tready    | code point
// m_       | out | m_tvalid / m_tready    | encoded byte, index, count, tlast
// cfg_     | in  | cfg_valid / cfg_ready  | byte limit
//
// One code point at a time: the block accepts it in idle, then sends its
// bytes in order (1 to 6 bytes, count set by length and byte limit), each
// held until taken. The byte counter in the datapath steps through them.
// Reset is synchronous, active low; byte limit returns to 8.
// A stall on m_ holds the current byte; s_tready stays low until the last
// byte has gone. Config writes are always taken.

module utf8_sequence_encoder_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] code_point
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [10:8] byte_index,
                                        // [13:11] reported_count, [15:14] zero
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data
);

    u8enc_pkg::dp_cmd_t    cmd;
    u8enc_pkg::dp_status_t status;
    logic [7:0] out_byte;
    logic [2:0] byte_index, reported_count;

    assign cfg_ready = 1'b1;

    u8enc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    u8enc_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .code_point     (s_tdata),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .status         (status),
        .out_byte       (out_byte),
        .byte_index     (byte_index),
        .reported_count (reported_count)
    );

    assign m_tdata = {2'b00, reported_count, byte_index, out_byte};
    assign m_tlast = status.last_byte;

    // one code point in flight at most
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while bytes pending");

    // an accepted code point starts with its lead byte
    a_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (m_tvalid && m_tdata[10:8] == 3'd0))
        else $error("sequence does not start at lead byte");

    // last byte handed off returns the block to idle
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("block not idle after last byte");

    // continuation bytes never reach the reported count
    a_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10:8] == 3'd0 || m_tdata[10:8] < m_tdata[13:11]))
        else $error("byte index beyond reported count");

endmodule

`default_nettype wire
